### rtl/core/sll_pkg.sv
// Shared types and constants of the string literal lexer.
package sll_pkg;

    // Input modes.
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_CHAR  = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_UNCLOSED   = 3'd1;
    localparam logic [2:0] ERR_BAD_ESCAPE = 3'd2;
    localparam logic [2:0] ERR_NO_TICK    = 3'd3;
    localparam logic [2:0] ERR_RANGE      = 3'd4;
    localparam logic [2:0] ERR_BAD_PREFIX = 3'd5;

    // Characters of interest.
    localparam logic [20:0] CH_TICK  = 21'h60;
    localparam logic [20:0] CH_DQ    = 21'h22;
    localparam logic [20:0] CH_SQ    = 21'h27;
    localparam logic [20:0] CH_NL    = 21'h0A;
    localparam logic [20:0] CH_PLUS  = 21'h2B;
    localparam logic [20:0] CH_LO_U  = 21'h75;
    localparam logic [20:0] CH_UP_U  = 21'h55;
    localparam logic [20:0] CH_LO_X  = 21'h78;
    localparam logic [20:0] CH_UP_X  = 21'h58;
    localparam logic [20:0] MAX_CP   = 21'h10FFFF;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Lexer phases.
    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_OPEN1 = 4'd1,
        PH_OPEN2 = 4'd2,
        PH_LINE  = 4'd3,
        PH_BLOCK = 4'd4,
        PH_TICK  = 4'd5,
        PH_UNI   = 4'd6,
        PH_HEX   = 4'd7
    } t_phase;

    // All results of one input item: held quotes first, then an optional final result.
    typedef struct packed {
        logic [1:0]  nq;
        logic        has_fin;
        logic [1:0]  kind;
        logic [20:0] ch;
        logic [2:0]  err;
        logic        spare;
        logic        blk;
        logic        esc;
    } t_bundle;

endpackage

### rtl/core/sll_front.sv
// Front part: lexer state machine that turns each input item into a result bundle.
module sll_front import sll_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_mode,
    input  logic [20:0] i_code_point,
    output logic        o_push,
    output t_bundle     o_bundle
);

    t_phase      r_phase, n_phase;
    logic        r_block, n_block;
    logic        r_esc, n_esc;
    logic [1:0]  r_pq, n_pq;
    logic [20:0] r_hex_acc, n_hex_acc;
    logic        r_hex_ovf, n_hex_ovf;

    logic [20:0] c;
    logic [20:0] q;
    logic        hex_ok;
    logic [3:0]  hex_d;
    logic [24:0] hex_t;
    logic        line_body;
    logic        block_body;
    logic        go_idle;
    t_bundle     bnd;

    assign c = i_code_point;
    assign q = r_esc ? CH_DQ : CH_SQ;

    // Hex digit decode.
    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (c >= 21'h30 && c <= 21'h39) begin
            hex_d = 4'(c - 21'h30);
        end else if (c >= 21'h61 && c <= 21'h66) begin
            hex_d = 4'(c - 21'h61 + 21'd10);
        end else if (c >= 21'h41 && c <= 21'h46) begin
            hex_d = 4'(c - 21'h41 + 21'd10);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign hex_t = {r_hex_acc, hex_d};

    // Next state and result bundle.
    always_comb begin
        n_phase    = r_phase;
        n_block    = r_block;
        n_esc      = r_esc;
        n_pq       = r_pq;
        n_hex_acc  = r_hex_acc;
        n_hex_ovf  = r_hex_ovf;
        line_body  = 1'b0;
        block_body = 1'b0;
        go_idle    = 1'b0;
        bnd.nq      = 2'd0;
        bnd.has_fin = 1'b0;
        bnd.kind    = KIND_CHAR;
        bnd.ch      = '0;
        bnd.err     = ERR_NONE;
        bnd.spare   = 1'b0;
        bnd.blk     = r_block;
        bnd.esc     = r_esc;

        unique case (i_mode)
            MODE_START: begin
                n_block   = 1'b0;
                n_pq      = 2'd0;
                n_hex_acc = '0;
                n_hex_ovf = 1'b0;
                if (c == CH_SQ) begin
                    n_esc   = 1'b0;
                    n_phase = PH_OPEN1;
                end else if (c == CH_DQ) begin
                    n_esc   = 1'b1;
                    n_phase = PH_OPEN1;
                end else begin
                    // Unknown opener: an empty literal finishes at once.
                    n_esc       = 1'b0;
                    n_phase     = PH_IDLE;
                    bnd.has_fin = 1'b1;
                    bnd.kind    = KIND_FINISH;
                    bnd.blk     = 1'b0;
                    bnd.esc     = 1'b0;
                end
            end
            MODE_CHAR: begin
                unique case (r_phase)
                    PH_OPEN1: begin
                        if (c == q) begin
                            n_phase = PH_OPEN2;
                        end else begin
                            n_phase   = PH_LINE;
                            line_body = 1'b1;
                        end
                    end
                    PH_OPEN2: begin
                        if (c == q) begin
                            n_block = 1'b1;
                            n_pq    = 2'd0;
                            n_phase = PH_BLOCK;
                        end else begin
                            // Empty line string; this character lies after it.
                            bnd.has_fin = 1'b1;
                            bnd.kind    = KIND_FINISH;
                            bnd.spare   = 1'b1;
                            go_idle     = 1'b1;
                        end
                    end
                    PH_LINE:  line_body  = 1'b1;
                    PH_BLOCK: block_body = 1'b1;
                    PH_TICK: begin
                        if (c == CH_DQ || c == CH_TICK) begin
                            bnd.has_fin = 1'b1;
                            bnd.ch      = c;
                            n_phase     = r_block ? PH_BLOCK : PH_LINE;
                        end else if (c == CH_LO_U || c == CH_UP_U) begin
                            n_phase = PH_UNI;
                        end else begin
                            bnd.has_fin = 1'b1;
                            bnd.kind    = KIND_ERROR;
                            bnd.err     = ERR_BAD_ESCAPE;
                            go_idle     = 1'b1;
                        end
                    end
                    PH_UNI: begin
                        if (c == CH_LO_X || c == CH_UP_X || c == CH_PLUS) begin
                            n_hex_acc = '0;
                            n_hex_ovf = 1'b0;
                            n_phase   = PH_HEX;
                        end else begin
                            bnd.has_fin = 1'b1;
                            bnd.kind    = KIND_ERROR;
                            bnd.err     = ERR_BAD_PREFIX;
                            go_idle     = 1'b1;
                        end
                    end
                    PH_HEX: begin
                        if (hex_ok) begin
                            // Once overflowed, further digits are ignored.
                            if (!r_hex_ovf) begin
                                n_hex_acc = hex_t[20:0];
                                if (hex_t > 25'(MAX_CP)) begin
                                    n_hex_ovf = 1'b1;
                                end
                            end
                        end else if (c == CH_TICK) begin
                            bnd.has_fin = 1'b1;
                            if (r_hex_ovf) begin
                                bnd.kind = KIND_ERROR;
                                bnd.err  = ERR_RANGE;
                                go_idle  = 1'b1;
                            end else begin
                                bnd.ch  = r_hex_acc;
                                n_phase = r_block ? PH_BLOCK : PH_LINE;
                            end
                        end else begin
                            bnd.has_fin = 1'b1;
                            bnd.kind    = KIND_ERROR;
                            bnd.err     = ERR_NO_TICK;
                            go_idle     = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_END: begin
                unique case (r_phase)
                    PH_OPEN2: begin
                        bnd.has_fin = 1'b1;
                        bnd.kind    = KIND_FINISH;
                        go_idle     = 1'b1;
                    end
                    PH_OPEN1, PH_LINE, PH_BLOCK: begin
                        bnd.has_fin = 1'b1;
                        bnd.kind    = KIND_ERROR;
                        bnd.err     = ERR_UNCLOSED;
                        go_idle     = 1'b1;
                    end
                    PH_TICK: begin
                        bnd.has_fin = 1'b1;
                        bnd.kind    = KIND_ERROR;
                        bnd.err     = ERR_BAD_ESCAPE;
                        go_idle     = 1'b1;
                    end
                    PH_UNI: begin
                        bnd.has_fin = 1'b1;
                        bnd.kind    = KIND_ERROR;
                        bnd.err     = ERR_BAD_PREFIX;
                        go_idle     = 1'b1;
                    end
                    PH_HEX: begin
                        bnd.has_fin = 1'b1;
                        bnd.kind    = KIND_ERROR;
                        bnd.err     = ERR_NO_TICK;
                        go_idle     = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        // Body character of a line string.
        if (line_body) begin
            bnd.has_fin = 1'b1;
            if (c == CH_NL) begin
                bnd.kind = KIND_ERROR;
                bnd.err  = ERR_UNCLOSED;
                go_idle  = 1'b1;
            end else if (c == q) begin
                bnd.kind = KIND_FINISH;
                go_idle  = 1'b1;
            end else if (r_esc && c == CH_TICK) begin
                bnd.has_fin = 1'b0;
                n_phase     = PH_TICK;
            end else begin
                bnd.ch = c;
            end
        end

        // Body character of a block string: quotes are held until the close is known.
        if (block_body) begin
            if (c == q) begin
                if (r_pq == 2'd2) begin
                    bnd.has_fin = 1'b1;
                    bnd.kind    = KIND_FINISH;
                    go_idle     = 1'b1;
                end else begin
                    n_pq = r_pq + 2'd1;
                end
            end else begin
                bnd.nq = r_pq;
                n_pq   = 2'd0;
                if (r_esc && c == CH_TICK) begin
                    n_phase = PH_TICK;
                end else begin
                    bnd.has_fin = 1'b1;
                    bnd.ch      = c;
                end
            end
        end

        // Return to idle after a finish or an error.
        if (go_idle) begin
            n_phase   = PH_IDLE;
            n_block   = 1'b0;
            n_esc     = 1'b0;
            n_pq      = 2'd0;
            n_hex_acc = '0;
            n_hex_ovf = 1'b0;
        end
    end

    assign o_bundle = bnd;
    assign o_push   = i_accept && (bnd.has_fin || (bnd.nq != 2'd0));

    // Lexer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_block   <= 1'b0;
            r_esc     <= 1'b0;
            r_pq      <= 2'd0;
            r_hex_acc <= '0;
            r_hex_ovf <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_block   <= n_block;
            r_esc     <= n_esc;
            r_pq      <= n_pq;
            r_hex_acc <= n_hex_acc;
            r_hex_ovf <= n_hex_ovf;
        end
    end

endmodule

### rtl/core/sll_queue.sv
// Short queue of result bundles between the front and the back.
module sll_queue import sll_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output t_bundle o_data,
    output logic    o_full,
    output logic    o_empty
);

    t_bundle         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/sll_back.sv
// Back part: hands out the results of each bundle one transfer at a time.
module sll_back import sll_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_bundle     i_bundle,
    input  logic        i_q_empty,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [1:0]  o_kind,
    output logic [20:0] o_char_out,
    output logic [2:0]  o_error_code,
    output logic        o_is_block,
    output logic        o_escapable,
    output logic        o_spare_char,
    output logic        o_last
);

    t_bundle    r_cur;
    logic       r_valid;
    logic [1:0] r_idx;
    logic [1:0] total;
    logic       is_last;
    logic       load;

    assign total   = r_cur.nq + {1'b0, r_cur.has_fin};
    assign is_last = (r_idx == total - 2'd1);
    assign load    = !r_valid || (i_pop && is_last);
    assign o_q_pop = load && !i_q_empty;
    assign o_empty = !r_valid;

    // Held quotes come first, then the final result.
    always_comb begin
        o_is_block  = r_cur.blk;
        o_escapable = r_cur.esc;
        o_last      = is_last;
        if (r_idx < r_cur.nq) begin
            o_kind       = KIND_CHAR;
            o_char_out   = r_cur.esc ? CH_DQ : CH_SQ;
            o_error_code = ERR_NONE;
            o_spare_char = 1'b0;
        end else begin
            o_kind       = r_cur.kind;
            o_char_out   = r_cur.ch;
            o_error_code = r_cur.err;
            o_spare_char = r_cur.spare;
        end
    end

    // Current bundle payload.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_bundle;
        end
    end

    // Valid flag and position within the bundle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= !i_q_empty;
            r_idx   <= 2'd0;
        end else if (i_pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

### rtl/core/string_literal_lexer.sv
// Top level of the string literal lexer: front, bundle queue and back.
// Path: an accepted item's bundle is written into the queue, then loaded into the back stage.
// Throughput: one input item per cycle while the queue has room; the back hands out one result
// per cycle while pop is held, and the four-bundle queue absorbs bursts.
// Reset: synchronous, active low; clears the lexer state, the queue and the output stage.
module string_literal_lexer import sll_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_mode,
    input  logic [20:0] i_code_point,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [20:0] o_char_out,
    output logic [2:0]  o_error_code,
    output logic        o_is_block,
    output logic        o_escapable,
    output logic        o_spare_char,
    output logic        o_last
);

    logic    accept;
    logic    f_push;
    t_bundle f_bundle;
    t_bundle q_data;
    logic    q_empty;
    logic    q_pop;

    // An input transfer happens whenever the queue has room.
    assign accept = push && !full;

    sll_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_mode       (i_mode),
        .i_code_point (i_code_point),
        .o_push       (f_push),
        .o_bundle     (f_bundle)
    );

    sll_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_bundle),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (full),
        .o_empty (q_empty)
    );

    sll_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bundle     (q_data),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_kind       (o_kind),
        .o_char_out   (o_char_out),
        .o_error_code (o_error_code),
        .o_is_block   (o_is_block),
        .o_escapable  (o_escapable),
        .o_spare_char (o_spare_char),
        .o_last       (o_last)
    );

endmodule
